>>> rtl/sidk_pkg.sv
// Shared types and constants of the softened inverse-distance kernel.
package sidk_pkg;

  localparam int IdxW    = 9;             // width of one cell index
  localparam int MaxHalf = 256;           // largest effective grid_half
  localparam int MW      = 20;            // width of 4*S+1
  localparam int TW      = 33;            // root estimate floor(2^32/sqrt(m))
  localparam int AW      = 53;            // running t*m
  localparam int PW      = 65;            // running t*t*m, up to 2^64
  localparam int SW      = 88;            // trial sum width
  localparam int NStage  = TW;            // one root bit per stage
  localparam int KernW   = 32;            // kernel_value width

  typedef struct packed {
    logic          err;  // some index at or beyond the doubled edge
    logic [MW-1:0] m;    // 4*S+1
  } item_t;

endpackage

>>> rtl/sidk_front.sv
// Front part: takes index triples, folds them and forms 4*S+1.
module sidk_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sidk_pkg::IdxW-1:0]    grid_half_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sidk_pkg::IdxW-1:0]    x_i,
  input  logic [sidk_pkg::IdxW-1:0]    y_i,
  input  logic [sidk_pkg::IdxW-1:0]    z_i,
  output logic                         push_o,
  input  logic                         push_ready_i,
  output sidk_pkg::item_t              item_o
);

  logic                      vld_q;
  logic [sidk_pkg::IdxW-1:0] x_q, y_q, z_q;
  logic [sidk_pkg::IdxW-1:0] half;
  logic [sidk_pkg::IdxW:0]   edge_len;
  logic                      ex, ey, ez;
  logic [sidk_pkg::IdxW-1:0] dx, dy, dz;
  logic [2*sidk_pkg::IdxW:0] ssum;

  // Fold one index to its wrap-around distance.
  function automatic logic [sidk_pkg::IdxW-1:0] fold(
    input logic [sidk_pkg::IdxW-1:0] i, input logic [sidk_pkg::IdxW:0] e);
    logic [sidk_pkg::IdxW:0] other;
    other = e - {1'b0, i};
    fold  = ({1'b0, i} <= other) ? i : other[sidk_pkg::IdxW-1:0];
  endfunction

  assign in_ready_o = !vld_q || push_ready_i;
  assign push_o     = vld_q && push_ready_i;

  // Hold the accepted word until the queue takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end
  end

  // Saturate the half edge and classify the indices.
  assign half     = (grid_half_i > sidk_pkg::IdxW'(sidk_pkg::MaxHalf))
                    ? sidk_pkg::IdxW'(sidk_pkg::MaxHalf) : grid_half_i;
  assign edge_len = {half, 1'b0};
  assign ex       = {1'b0, x_q} >= edge_len;
  assign ey       = {1'b0, y_q} >= edge_len;
  assign ez       = {1'b0, z_q} >= edge_len;
  assign dx       = fold(x_q, edge_len);
  assign dy       = fold(y_q, edge_len);
  assign dz       = fold(z_q, edge_len);
  assign ssum     = (2*sidk_pkg::IdxW+1)'(dx) * (2*sidk_pkg::IdxW+1)'(dx)
                  + (2*sidk_pkg::IdxW+1)'(dy) * (2*sidk_pkg::IdxW+1)'(dy)
                  + (2*sidk_pkg::IdxW+1)'(dz) * (2*sidk_pkg::IdxW+1)'(dz);

  assign item_o.err = ex || ey || ez;
  assign item_o.m   = {ssum[sidk_pkg::MW-3:0], 2'b01};

endmodule

>>> rtl/sidk_queue.sv
// Two-entry queue between the front and the root pipeline.
module sidk_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  sidk_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output sidk_pkg::item_t pop_item_o
);

  sidk_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_item_o   = mem_q[rd_q];

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/sidk_root.sv
// Back part: bit-per-stage inverse square root pipeline and output register.
module sidk_root (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sidk_pkg::item_t               in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sidk_pkg::KernW-1:0]    kernel_o,
  output logic                          err_o
);

  localparam int N = sidk_pkg::NStage;

  logic                       en;
  logic                       in_v   [N];
  logic                       in_e   [N];
  logic [sidk_pkg::MW-1:0]    in_m   [N];
  logic [sidk_pkg::TW-1:0]    in_t   [N];
  logic [sidk_pkg::AW-1:0]    in_a   [N];
  logic [sidk_pkg::PW-1:0]    in_p   [N];
  logic                       st_v_q [1:N];
  logic                       st_e_q [1:N];
  logic [sidk_pkg::MW-1:0]    st_m_q [1:N];
  logic [sidk_pkg::TW-1:0]    st_t_q [1:N];
  logic [sidk_pkg::AW-1:0]    st_a_q [1:N];
  logic [sidk_pkg::PW-1:0]    st_p_q [1:N];
  logic                       out_v_q;
  logic [sidk_pkg::KernW-1:0] kern_q;
  logic                       err_q;
  logic [sidk_pkg::TW:0]      rnd;
  logic [sidk_pkg::KernW-1:0] mag;

  // Whole pipeline moves unless the output word is stalled.
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    logic [sidk_pkg::SW-1:0] trial;
    logic                    ok;

    if (j == 0) begin : g_head
      assign in_v[j] = in_valid_i;
      assign in_e[j] = in_item_i.err;
      assign in_m[j] = in_item_i.m;
      assign in_t[j] = '0;
      assign in_a[j] = '0;
      assign in_p[j] = '0;
    end else begin : g_link
      assign in_v[j] = st_v_q[j];
      assign in_e[j] = st_e_q[j];
      assign in_m[j] = st_m_q[j];
      assign in_t[j] = st_t_q[j];
      assign in_a[j] = st_a_q[j];
      assign in_p[j] = st_p_q[j];
    end

    // Try setting root bit K: (t+b)^2 m = t^2 m + 2 b t m + b^2 m <= 2^64.
    assign trial = sidk_pkg::SW'(in_p[j]) + (sidk_pkg::SW'(in_a[j]) << (K + 1))
                 + (sidk_pkg::SW'(in_m[j]) << (2 * K));
    assign ok    = trial <= (sidk_pkg::SW'(1) << 64);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[j+1] <= 1'b0;
      end else if (en) begin
        st_v_q[j+1] <= in_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_e_q[j+1] <= in_e[j];
        st_m_q[j+1] <= in_m[j];
        if (ok) begin
          st_t_q[j+1] <= in_t[j] | (sidk_pkg::TW'(1) << K);
          st_p_q[j+1] <= trial[sidk_pkg::PW-1:0];
          st_a_q[j+1] <= in_a[j] + (sidk_pkg::AW'(in_m[j]) << K);
        end else begin
          st_t_q[j+1] <= in_t[j];
          st_p_q[j+1] <= in_p[j];
          st_a_q[j+1] <= in_a[j];
        end
      end
    end
  end

  // Round half the doubled root and negate.
  assign rnd = {1'b0, st_t_q[N]} + (sidk_pkg::TW+1)'(1);
  assign mag = rnd[sidk_pkg::KernW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= st_v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q  <= st_e_q[N];
      kern_q <= st_e_q[N] ? '0 : ('0 - mag);
    end
  end

  assign out_valid_o = out_v_q;
  assign kernel_o    = kern_q;
  assign err_o       = err_q;

endmodule

>>> rtl/softened_inverse_distance_kernel.sv
// Top level of the softened inverse-distance kernel.
// Use:
//   Slave stream s_axis carries one index triple per word; tdata holds
//   x_index [8:0], y_index [17:9], z_index [26:18], zeros above.
//   Master stream m_axis returns one word per input word, in order:
//   tdata is kernel_value = -1/sqrt(S+1/4) with 30 fraction bits,
//   tuser is index_error (kernel_value then reads zero).
//   grid_half is written through cfg_we_i / cfg_wdata_i while idle; values
//   above 256 act as 256, zero flags every index.
// Timing:
//   One word per cycle sustained while m_axis_tready_i is high. Each word
//   accepted passes the input register, the queue, 33 root stages (one
//   root bit each) and the output register, in that order.
// Reset:
//   rst_ni clears all valid state and loads grid_half with 64.
// Backpressure:
//   With an output word stalled the root pipeline freezes; the two-word
//   queue and the input register absorb words until s_axis_tready_o drops.
module softened_inverse_distance_kernel (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,     // grid_half
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // x_index, y_index, z_index, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // kernel_value
  output logic        m_axis_tuser_o   // index_error
);

  logic [sidk_pkg::IdxW-1:0] grid_half_q;
  logic                      push, push_ready, pop_valid, pop_ready;
  sidk_pkg::item_t           push_item, pop_item;

  // Hold the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_half_q <= sidk_pkg::IdxW'(64);
    end else if (cfg_we_i) begin
      grid_half_q <= cfg_wdata_i;
    end
  end

  sidk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .grid_half_i  (grid_half_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .x_i          (s_axis_tdata_i[8:0]),
    .y_i          (s_axis_tdata_i[17:9]),
    .z_i          (s_axis_tdata_i[26:18]),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (push_item)
  );

  sidk_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop_valid && pop_ready),
    .pop_item_o   (pop_item)
  );

  sidk_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_item_i   (pop_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .kernel_o    (m_axis_tdata_o),
    .err_o       (m_axis_tuser_o)
  );

  // A flagged word carries a zero kernel.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 32'd0)
    else $error("flagged word with nonzero kernel");

  // A clean word is strictly negative.
  a_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[31])
    else $error("clean kernel not negative");

  // Nothing leaves right after reset.
  a_rst : assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid right after reset");

endmodule
